FILE: rtl/crp_pkg.sv
`default_nettype none

package crp_pkg;

   // Payload widths fixed by the channel format
   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned UNIT_TEXT_W = 64;
   localparam int unsigned UNIT_LEN_W  = 4;
   localparam int unsigned POS_W       = 32;

   // Defaults for the top-level parameters
   localparam int unsigned DEF_MAX_UNIT_CHARS = 8;
   localparam int unsigned DEF_NUMBER_BITS    = 31;

   // Characters of the header grammar
   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_DASH   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] DIGIT_FIRST = 8'd48;
   localparam logic [CHAR_W-1:0] DIGIT_LIMIT = 8'd58;
   localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'd65;
   localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'd90;
   localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'd97;
   localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'd122;

   // Parse phases
   typedef enum logic [3:0] {
      PH_UNIT_FIRST,
      PH_UNIT,
      PH_GAP,
      PH_START,
      PH_STAR,
      PH_DASH,
      PH_END,
      PH_SLASH,
      PH_LEN,
      PH_LEN_STAR,
      PH_STAR_SLASH,
      PH_ERROR
   } phase_type;

endpackage

`default_nettype wire

FILE: rtl/crp_stream_if.sv
`default_nettype none

// Character channel into the parser
interface crp_req_if;
   import crp_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// Parse result channel
interface crp_rsp_if;
   import crp_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    ok;
   logic [UNIT_TEXT_W-1:0]  unit_text;
   logic [UNIT_LEN_W-1:0]   unit_length;
   logic                    unit_truncated;
   logic signed [POS_W-1:0] range_start;
   logic signed [POS_W-1:0] range_end;
   logic signed [POS_W-1:0] total_length;

   modport source (output valid, output ok, output unit_text, output unit_length,
                   output unit_truncated, output range_start, output range_end,
                   output total_length, input ready);
   modport sink   (input valid, input ok, input unit_text, input unit_length,
                   input unit_truncated, input range_start, input range_end,
                   input total_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/content_range_parser_core.sv
`default_nettype none
// Content-Range parser: one character word per cycle, no bubbles.
// The result word is registered and is valid in the cycle after the final character is accepted.
// Throughput: 1 character per cycle; req stalls only while a result is held and
// rsp ready is low (single result register).
// Reset: synchronous, clears parse phase, unit letters, accumulators and result valid.

module content_range_parser_core #(
   parameter int unsigned MAX_UNIT_CHARS = crp_pkg::DEF_MAX_UNIT_CHARS,
   parameter int unsigned NUMBER_BITS    = crp_pkg::DEF_NUMBER_BITS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   crp_req_if.sink    req_if,
   crp_rsp_if.source  rsp_if
);
   import crp_pkg::*;

   localparam int unsigned NB = NUMBER_BITS;
   localparam logic [NB-1:0] NUM_MAX = '1;
   localparam logic [UNIT_LEN_W-1:0] UNIT_CAP = UNIT_LEN_W'(MAX_UNIT_CHARS);

   // Multiply by ten, add one digit, saturate at the accumulator maximum
   function automatic logic [NB-1:0] acc_step(input logic [NB-1:0] acc,
                                               input logic [3:0] digit);
      logic [NB+3:0] wide;
      wide = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + (NB+4)'(digit);
      if (wide > {4'b0000, NUM_MAX}) begin
         return NUM_MAX;
      end
      return wide[NB-1:0];
   endfunction

   // Parse state
   phase_type               phase_ff, phase_in, phase_adv;
   logic [UNIT_TEXT_W-1:0]  unit_store_ff, unit_store_in, unit_store_adv;
   logic [UNIT_LEN_W-1:0]   unit_count_ff, unit_count_in, unit_count_adv;
   logic                    unit_ovf_ff, unit_ovf_in, unit_ovf_adv;
   logic [NB-1:0]           start_ff, start_in, start_adv;
   logic [NB-1:0]           end_ff, end_in, end_adv;
   logic [NB-1:0]           len_ff, len_in, len_adv;
   logic                    rstar_ff, rstar_in, rstar_adv;
   logic                    lstar_ff, lstar_in, lstar_adv;

   // Result register
   logic                    rsp_valid_ff;
   logic                    ok_ff;
   logic [UNIT_TEXT_W-1:0]  text_ff;
   logic [UNIT_LEN_W-1:0]   ulen_ff;
   logic                    utrunc_ff;
   logic [POS_W-1:0]        rstart_ff, rend_ff, total_ff;

   logic              req_accept;
   logic [CHAR_W-1:0] c;
   logic              is_letter, is_digit, is_space, is_star, is_dash, is_slash;
   logic [3:0]        digit;
   logic              take_letter, take_start, take_end, take_len, set_rstar, set_lstar;
   logic              ok_adv;
   logic [63:0]       start_ext, end_ext, len_ext;

   // Accept a word whenever the result register is free or draining
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   // Classify the incoming character
   assign c         = req_if.char_code;
   assign is_letter = (c >= UPPER_FIRST && c <= UPPER_LAST) ||
                      (c >= LOWER_FIRST && c <= LOWER_LAST);
   assign is_digit  = (c >= DIGIT_FIRST) && (c < DIGIT_LIMIT);
   assign is_space  = (c == CHAR_SPACE);
   assign is_star   = (c == CHAR_STAR);
   assign is_dash   = (c == CHAR_DASH);
   assign is_slash  = (c == CHAR_SLASH);
   assign digit     = c[3:0];

   // Next parse phase
   always_comb begin
      phase_adv = PH_ERROR;
      unique case (phase_ff)
         PH_UNIT_FIRST: begin
            if (is_letter) phase_adv = PH_UNIT;
         end
         PH_UNIT: begin
            if (is_letter)     phase_adv = PH_UNIT;
            else if (is_space) phase_adv = PH_GAP;
         end
         PH_GAP: begin
            if (is_space)      phase_adv = PH_GAP;
            else if (is_digit) phase_adv = PH_START;
            else if (is_star)  phase_adv = PH_STAR;
         end
         PH_START: begin
            if (is_digit)     phase_adv = PH_START;
            else if (is_dash) phase_adv = PH_DASH;
         end
         PH_STAR: begin
            if (is_slash) phase_adv = PH_STAR_SLASH;
         end
         PH_DASH: begin
            if (is_digit) phase_adv = PH_END;
         end
         PH_END: begin
            if (is_digit)      phase_adv = PH_END;
            else if (is_slash) phase_adv = PH_SLASH;
         end
         PH_SLASH: begin
            if (is_digit)     phase_adv = PH_LEN;
            else if (is_star) phase_adv = PH_LEN_STAR;
         end
         PH_STAR_SLASH, PH_LEN: begin
            if (is_digit) phase_adv = PH_LEN;
         end
         default: phase_adv = PH_ERROR;
      endcase
   end

   // Datapath controls for the current phase
   always_comb begin
      take_letter = 1'b0;
      take_start  = 1'b0;
      take_end    = 1'b0;
      take_len    = 1'b0;
      set_rstar   = 1'b0;
      set_lstar   = 1'b0;
      unique case (phase_ff)
         PH_UNIT_FIRST, PH_UNIT:     take_letter = is_letter;
         PH_GAP: begin
            take_start = is_digit;
            set_rstar  = is_star;
         end
         PH_START:                   take_start = is_digit;
         PH_DASH, PH_END:            take_end   = is_digit;
         PH_SLASH: begin
            take_len  = is_digit;
            set_lstar = is_star;
         end
         PH_STAR_SLASH, PH_LEN:      take_len   = is_digit;
         default: ;
      endcase
   end

   // Apply the character to letters and accumulators
   always_comb begin
      unit_store_adv = unit_store_ff;
      unit_count_adv = unit_count_ff;
      unit_ovf_adv   = unit_ovf_ff;
      if (take_letter) begin
         if (unit_count_ff < UNIT_CAP) begin
            unit_store_adv = unit_store_ff |
               (UNIT_TEXT_W'(c) << {unit_count_ff[2:0], 3'b000});
            unit_count_adv = unit_count_ff + UNIT_LEN_W'(1);
         end else begin
            unit_ovf_adv = 1'b1;
         end
      end
      start_adv = take_start ? acc_step(start_ff, digit) : start_ff;
      end_adv   = take_end   ? acc_step(end_ff, digit)   : end_ff;
      len_adv   = take_len   ? acc_step(len_ff, digit)   : len_ff;
      rstar_adv = rstar_ff || set_rstar;
      lstar_adv = lstar_ff || set_lstar;
   end

   // Drop back to the start state after the final character
   always_comb begin
      if (req_if.last_char) begin
         phase_in      = PH_UNIT_FIRST;
         unit_store_in = '0;
         unit_count_in = '0;
         unit_ovf_in   = 1'b0;
         start_in      = '0;
         end_in        = '0;
         len_in        = '0;
         rstar_in      = 1'b0;
         lstar_in      = 1'b0;
      end else begin
         phase_in      = phase_adv;
         unit_store_in = unit_store_adv;
         unit_count_in = unit_count_adv;
         unit_ovf_in   = unit_ovf_adv;
         start_in      = start_adv;
         end_in        = end_adv;
         len_in        = len_adv;
         rstar_in      = rstar_adv;
         lstar_in      = lstar_adv;
      end
   end

   assign ok_adv    = (phase_adv == PH_LEN) || (phase_adv == PH_LEN_STAR);
   assign start_ext = 64'(start_adv);
   assign end_ext   = 64'(end_adv);
   assign len_ext   = 64'(len_adv);

   // Advance parse state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_UNIT_FIRST;
         unit_store_ff <= '0;
         unit_count_ff <= '0;
         unit_ovf_ff   <= 1'b0;
         start_ff      <= '0;
         end_ff        <= '0;
         len_ff        <= '0;
         rstar_ff      <= 1'b0;
         lstar_ff      <= 1'b0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         unit_store_ff <= unit_store_in;
         unit_count_ff <= unit_count_in;
         unit_ovf_ff   <= unit_ovf_in;
         start_ff      <= start_in;
         end_ff        <= end_in;
         len_ff        <= len_in;
         rstar_ff      <= rstar_in;
         lstar_ff      <= lstar_in;
      end
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept && req_if.last_char) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load result payload; zero every field of a rejected value
   always_ff @(posedge clock) begin
      if (req_accept && req_if.last_char) begin
         ok_ff     <= ok_adv;
         text_ff   <= ok_adv ? unit_store_adv : '0;
         ulen_ff   <= ok_adv ? unit_count_adv : '0;
         utrunc_ff <= ok_adv && unit_ovf_adv;
         rstart_ff <= !ok_adv ? '0 : (rstar_adv ? '1 : start_ext[POS_W-1:0]);
         rend_ff   <= !ok_adv ? '0 : (rstar_adv ? '1 : end_ext[POS_W-1:0]);
         total_ff  <= !ok_adv ? '0 : (lstar_adv ? '1 : len_ext[POS_W-1:0]);
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.ok             = ok_ff;
   assign rsp_if.unit_text      = text_ff;
   assign rsp_if.unit_length    = ulen_ff;
   assign rsp_if.unit_truncated = utrunc_ff;
   assign rsp_if.range_start    = $signed(rstart_ff);
   assign rsp_if.range_end      = $signed(rend_ff);
   assign rsp_if.total_length   = $signed(total_ff);

   // Checks
   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_if.last_char |=> phase_ff == PH_UNIT_FIRST && rsp_valid_ff)
      else $error("parser did not restart after final character");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !ok_ff |-> text_ff == '0 && ulen_ff == '0 && !utrunc_ff &&
                                 rstart_ff == '0 && rend_ff == '0 && total_ff == '0)
      else $error("rejected result carries nonzero fields");

   a_unit_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ulen_ff <= UNIT_CAP)
      else $error("unit length beyond capacity");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_if.ready)
      else $error("input stalled with an empty result register");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import crp_pkg::*;

   localparam int unsigned UNIT_CHARS   = DEF_MAX_UNIT_CHARS;
   localparam int unsigned ACCUM_BITS   = DEF_NUMBER_BITS;
   localparam logic [63:0] ACCUM_LIMIT  = (64'd1 << ACCUM_BITS) - 64'd1;
   localparam int unsigned RANDOM_CHARS = 1700;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned STALL_LIMIT  = 20000;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct packed {
      logic                    ok;
      logic [UNIT_TEXT_W-1:0]  unit_text;
      logic [UNIT_LEN_W-1:0]   unit_length;
      logic                    unit_truncated;
      logic signed [POS_W-1:0] range_start;
      logic signed [POS_W-1:0] range_end;
      logic signed [POS_W-1:0] total_length;
   } range_result_t;

   typedef struct {
      string         text;
      bit            typed;
      range_result_t want;
   } header_row_t;

   logic clock = 1'b0;
   logic reset;

   crp_req_if req_ch ();
   crp_rsp_if rsp_ch ();

   content_range_parser_core #(
      .MAX_UNIT_CHARS (UNIT_CHARS),
      .NUMBER_BITS    (ACCUM_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #5 clock = ~clock;

   // Parsed results still owed by the block, oldest first
   range_result_t parsed_q[$];
   int unsigned   mismatch_count = 0;
   int unsigned   send_idle_pct  = 0;
   int unsigned   recv_idle_pct  = 0;
   int unsigned   holds_asked    = 0;
   int unsigned   holds_served   = 0;
   logic [7:0]    header_chars[$];

   // Shadow parse state
   phase_type   parse_phase;
   logic [63:0] unit_acc;
   int unsigned letter_count;
   bit          long_unit;
   logic [63:0] first_acc;
   logic [63:0] last_acc;
   logic [63:0] total_acc;
   bit          star_range;
   bit          star_total;

   function automatic bit is_letter(logic [7:0] c);
      return (c >= UPPER_FIRST && c <= UPPER_LAST) || (c >= LOWER_FIRST && c <= LOWER_LAST);
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= DIGIT_FIRST && c < DIGIT_LIMIT;
   endfunction

   // Multiply by ten and add, clamped at the accumulator ceiling
   function automatic logic [63:0] add_digit(logic [63:0] acc, logic [7:0] c);
      logic [63:0] d;
      d = 64'(c - DIGIT_FIRST);
      if (acc > (ACCUM_LIMIT - d) / 10) return ACCUM_LIMIT;
      return acc * 10 + d;
   endfunction

   function automatic range_result_t make_result(bit ok, logic [63:0] text, int unsigned len,
                                                 int first, int last, int total);
      range_result_t r;
      r.ok             = ok;
      r.unit_text      = text;
      r.unit_length    = len[UNIT_LEN_W-1:0];
      r.unit_truncated = 1'b0;
      r.range_start    = first;
      r.range_end      = last;
      r.total_length   = total;
      return r;
   endfunction

   task automatic clear_parse();
      parse_phase  = PH_UNIT_FIRST;
      unit_acc     = '0;
      letter_count = 0;
      long_unit    = 1'b0;
      first_acc    = '0;
      last_acc     = '0;
      total_acc    = '0;
      star_range   = 1'b0;
      star_total   = 1'b0;
   endtask

   task automatic add_letter(logic [7:0] c);
      if (letter_count < UNIT_CHARS) begin
         unit_acc |= 64'(c) << (letter_count * 8);
         letter_count++;
      end else begin
         long_unit = 1'b1;
      end
   endtask

   // Advance the shadow parser by one character; report the result on the last one
   task automatic parse_char(input logic [7:0] c, input logic last,
                             output bit produced, output range_result_t res);
      phase_type next;
      next = PH_ERROR;
      case (parse_phase)
         PH_UNIT_FIRST: begin
            if (is_letter(c)) begin add_letter(c); next = PH_UNIT; end
         end
         PH_UNIT: begin
            if (is_letter(c)) begin add_letter(c); next = PH_UNIT; end
            else if (c == CHAR_SPACE) next = PH_GAP;
         end
         PH_GAP: begin
            if (c == CHAR_SPACE) next = PH_GAP;
            else if (is_digit(c)) begin first_acc = add_digit(first_acc, c); next = PH_START; end
            else if (c == CHAR_STAR) begin star_range = 1'b1; next = PH_STAR; end
         end
         PH_START: begin
            if (is_digit(c)) begin first_acc = add_digit(first_acc, c); next = PH_START; end
            else if (c == CHAR_DASH) next = PH_DASH;
         end
         PH_STAR: begin
            if (c == CHAR_SLASH) next = PH_STAR_SLASH;
         end
         PH_DASH: begin
            if (is_digit(c)) begin last_acc = add_digit(last_acc, c); next = PH_END; end
         end
         PH_END: begin
            if (is_digit(c)) begin last_acc = add_digit(last_acc, c); next = PH_END; end
            else if (c == CHAR_SLASH) next = PH_SLASH;
         end
         PH_SLASH: begin
            if (is_digit(c)) begin total_acc = add_digit(total_acc, c); next = PH_LEN; end
            else if (c == CHAR_STAR) begin star_total = 1'b1; next = PH_LEN_STAR; end
         end
         PH_STAR_SLASH, PH_LEN: begin
            if (is_digit(c)) begin total_acc = add_digit(total_acc, c); next = PH_LEN; end
         end
         default: ;
      endcase
      parse_phase = next;
      produced = last;
      res = '0;
      if (last) begin
         if (parse_phase == PH_LEN || parse_phase == PH_LEN_STAR) begin
            res.ok             = 1'b1;
            res.unit_text      = unit_acc;
            res.unit_length    = letter_count[UNIT_LEN_W-1:0];
            res.unit_truncated = long_unit;
            res.range_start    = star_range ? '1 : first_acc[POS_W-1:0];
            res.range_end      = star_range ? '1 : last_acc[POS_W-1:0];
            res.total_length   = star_total ? '1 : total_acc[POS_W-1:0];
         end
         clear_parse();
      end
   endtask

   // Offer one character word, wait for acceptance, then predict
   task automatic send_char(input logic [7:0] c, input logic last,
                            output bit produced, output range_result_t res);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= c;
      req_ch.last_char <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      parse_char(c, last, produced, res);
   endtask

   // Drop valid and hold until every owed result has arrived
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (parsed_q.size() != 0);
   endtask

   function automatic logic [7:0] random_letter();
      int unsigned r;
      r = $urandom_range(0, 51);
      return (r < 26) ? UPPER_FIRST + 8'(r) : LOWER_FIRST + 8'(r - 26);
   endfunction

   task automatic push_number();
      string digits;
      case ($urandom_range(0, 11))
         0: digits = "2147483647";
         1: digits = "2147483648";
         2: begin
            digits = "";
            repeat ($urandom_range(11, 14))
               digits = {digits, string'(8'(DIGIT_FIRST + $urandom_range(0, 9)))};
         end
         default: begin
            digits = "";
            repeat ($urandom_range(1, 4))
               digits = {digits, string'(8'(DIGIT_FIRST + $urandom_range(0, 9)))};
         end
      endcase
      for (int i = 0; i < digits.len(); i++) header_chars.push_back(digits[i]);
   endtask

   // Build one header value: mostly well-formed, some damaged, some pure noise
   task automatic build_header();
      int unsigned kind;
      int unsigned pos;
      header_chars.delete();
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 8)) header_chars.push_back(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(9, 12)) header_chars.push_back(random_letter());
         else
            repeat ($urandom_range(1, 8)) header_chars.push_back(random_letter());
         repeat ($urandom_range(1, 3)) header_chars.push_back(CHAR_SPACE);
         if ($urandom_range(0, 3) == 0) begin
            header_chars.push_back(CHAR_STAR);
            header_chars.push_back(CHAR_SLASH);
            case ($urandom_range(0, 7))
               0: ;
               1: header_chars.push_back(CHAR_STAR);
               default: push_number();
            endcase
         end else begin
            push_number();
            header_chars.push_back(CHAR_DASH);
            push_number();
            header_chars.push_back(CHAR_SLASH);
            if ($urandom_range(0, 4) == 0) header_chars.push_back(CHAR_STAR);
            else push_number();
         end
         // Damage: overwrite one character or cut the value short
         if (kind >= 86) begin
            pos = $urandom_range(0, header_chars.size() - 1);
            if ($urandom_range(0, 1) == 0) header_chars[pos] = 8'($urandom_range(0, 255));
            else header_chars = header_chars[0:pos];
         end
      end
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch in %s: expected %h, got %h", name, want, got);
      end
   endtask

   // Check each result word against the oldest prediction
   always @(posedge clock) begin : result_check
      range_result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (parsed_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result word: ok %b start %0d end %0d total %0d",
                        rsp_ch.ok, rsp_ch.range_start, rsp_ch.range_end, rsp_ch.total_length);
         end else begin
            want = parsed_q.pop_front();
            check_field("ok", rsp_ch.ok, want.ok);
            check_field("unit_text", rsp_ch.unit_text, want.unit_text);
            check_field("unit_length", rsp_ch.unit_length, want.unit_length);
            check_field("unit_truncated", rsp_ch.unit_truncated, want.unit_truncated);
            check_field("range_start", rsp_ch.range_start, want.range_start);
            check_field("range_end", rsp_ch.range_end, want.range_end);
            check_field("total_length", rsp_ch.total_length, want.total_length);
         end
      end
   end

   // Result side: random stalls, plus long hold-offs on request
   initial begin : result_sink
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // End the run when neither channel moves a word for too long
   always @(posedge clock) begin : stall_watch
      int unsigned quiet;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : header_stream
      header_row_t   rows[5];
      bit            produced;
      range_result_t res;
      int unsigned   sent;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.char_code <= '0;
      req_ch.last_char <= 1'b0;
      clear_parse();

      rows[0] = '{"a 0-0/0", 1'b1, make_result(1'b1, 64'h61, 1, 0, 0, 0)};
      rows[1] = '{"Z */9",   1'b1, make_result(1'b1, 64'h5A, 1, -1, -1, 9)};
      rows[2] = '{"\377",    1'b1, make_result(1'b0, 64'h0, 0, 0, 0, 0)};
      rows[3] = '{"a */*",   1'b1, make_result(1'b0, 64'h0, 0, 0, 0, 0)};
      rows[4] = '{"zB 1-2/*", 1'b0, '0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed values
      send_idle_pct = 36;
      recv_idle_pct = 63;
      foreach (rows[r]) begin
         for (int i = 0; i < rows[r].text.len(); i++) begin
            send_char(rows[r].text[i], i == rows[r].text.len() - 1, produced, res);
            if (produced) parsed_q.push_back(rows[r].typed ? rows[r].want : res);
         end
      end

      // Random values in three idling phases
      sent = 0;
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct = 36; recv_idle_pct = 63; end
            1: begin send_idle_pct = 63; recv_idle_pct = 36; end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               drain_results();
               holds_asked++;
            end
         endcase
         while (sent < (ph + 1) * RANDOM_CHARS / 3) begin
            build_header();
            foreach (header_chars[i]) begin
               send_char(header_chars[i], i == header_chars.size() - 1, produced, res);
               sent++;
               if (produced) parsed_q.push_back(res);
            end
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
